// ===== hdl/lfsf_pkg.sv =====
// ----------------------------------------------------------------------------
// lfsf_pkg
// Shared widths, limits and reset values for the largest free square finder.
// ----------------------------------------------------------------------------
package lfsf_pkg;

	// Default grid limits
	localparam int MAX_COLS_DEF = 1024;
	localparam int MAX_ROWS_DEF = 1024;

	// Field widths
	localparam int SIZE_W = 11;
	localparam int POS_W  = 10;

	// Stream word widths, padded to whole bytes
	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 48;

	// Saturation limit of a square size
	localparam logic [SIZE_W-1:0] SIZE_SAT = {SIZE_W{1'b1}};

	// Row width after reset
	localparam logic [SIZE_W-1:0] ROW_WIDTH_RST = SIZE_W'(1024);

endpackage

// ===== hdl/largest_free_square_finder.sv =====
// ----------------------------------------------------------------------------
// largest_free_square_finder
// Maximal-square dynamic programming over a grid streamed in row-major order,
// with a line buffer of the previous row's sizes and best-square tracking.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Word                             Accepted when
//  s_axis    in         tdata[0] cell_free, tlast        tvalid & tready
//  m_axis    out        tdata sizes/pos, tlast done      tvalid & tready
//  cfg       in         row_width (11 bit)               cfg_wr_en
//
//  One cell per cycle sustained while m_axis does not stall; a cell's result
//  is presented on m_axis from the output register (line buffer read into the
//  compute stage, then the minimum into the output register).
//  The single-port read of the line buffer sets the rate; a write to the same
//  entry in the cycle of its read is forwarded.
//  Reset clears counters, best square and valid flags; the line buffer holds
//  no reset value and is written by the first row of each grid.
//  A stall on m_axis holds the output register and the compute stage, and
//  tready drops only when both are full.
// ----------------------------------------------------------------------------
module largest_free_square_finder #(
	parameter int MAX_COLS = lfsf_pkg::MAX_COLS_DEF,
	parameter int MAX_ROWS = lfsf_pkg::MAX_ROWS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	// cfg: row_width
	input  logic                               cfg_wr_en,
	input  logic [lfsf_pkg::SIZE_W-1:0]        cfg_wr_data,
	// s_axis tdata: [0] cell_free, [7:1] zero
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [lfsf_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
	input  logic                               s_axis_tlast,
	// m_axis tdata: [10:0] square_size, [21:11] best_size, [31:22] best_row,
	//               [41:32] best_col, [47:42] zero
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	output logic [lfsf_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
	output logic                               m_axis_tlast
);

	localparam int SW   = lfsf_pkg::SIZE_W;
	localparam int PW   = lfsf_pkg::POS_W;
	localparam int CW   = $clog2(MAX_COLS);
	localparam int RW   = $clog2(MAX_ROWS);
	localparam int CMPW = (CW + 1 > SW) ? CW + 1 : SW;

	// Configuration
	logic [SW-1:0] row_width_q;

	// Position counters of the next cell
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;

	// Compute stage
	logic          valid_s1;
	logic          free_s1;
	logic          last_s1;
	logic          first_s1;
	logic [CW-1:0] col_s1;
	logic [RW-1:0] row_s1;
	logic [SW-1:0] rd_data_s1;
	logic          fwd_s1;
	logic [SW-1:0] fwd_data_s1;

	// Neighbour and best-square state
	logic [SW-1:0] left_q;
	logic [SW-1:0] diag_q;
	logic [SW-1:0] best_q;
	logic [PW-1:0] best_row_q;
	logic [PW-1:0] best_col_q;

	// Output register
	logic          out_valid_q;
	logic          out_last_q;
	logic [SW-1:0] out_size_q;
	logic [SW-1:0] out_best_q;
	logic [PW-1:0] out_row_q;
	logic [PW-1:0] out_col_q;

	// Line buffer
	logic [SW-1:0] line_mem [MAX_COLS];

	logic            adv1;
	logic            acc;
	logic [CW:0]     col_inc;
	logic            row_end;
	logic [SW-1:0]   up;
	logic [SW-1:0]   min_lu;
	logic [SW-1:0]   min3;
	logic [SW-1:0]   size_c;
	logic            better;
	logic [SW-1:0]   best_nxt;
	logic [PW-1:0]   best_row_nxt;
	logic [PW-1:0]   best_col_nxt;

	// Handshake: the compute stage moves on when the output register frees
	assign adv1          = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv1;
	assign acc           = s_axis_tvalid && s_axis_tready;

	// Row end test against the effective width
	always_comb begin
		col_inc = {1'b0, col_q} + (CW+1)'(1);
		row_end = (row_width_q == '0)
			|| (CMPW'(col_inc) >= CMPW'(row_width_q))
			|| (CMPW'(col_inc) >= CMPW'(MAX_COLS));
	end

	// Size of the square ending at the cell in the compute stage
	always_comb begin
		up     = fwd_s1 ? fwd_data_s1 : rd_data_s1;
		min_lu = (left_q < up) ? left_q : up;
		min3   = (diag_q < min_lu) ? diag_q : min_lu;
		if (!free_s1) begin
			size_c = '0;
		end else if (first_s1) begin
			size_c = SW'(1);
		end else if (min3 == lfsf_pkg::SIZE_SAT) begin
			size_c = lfsf_pkg::SIZE_SAT;
		end else begin
			size_c = min3 + SW'(1);
		end
		better       = size_c > best_q;
		best_nxt     = better ? size_c : best_q;
		best_row_nxt = better ? PW'(row_s1) : best_row_q;
		best_col_nxt = better ? PW'(col_s1) : best_col_q;
	end

	// Hold the row width
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= lfsf_pkg::ROW_WIDTH_RST;
		end else if (cfg_wr_en) begin
			row_width_q <= cfg_wr_data;
		end
	end

	// Advance the column and row counters on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (s_axis_tlast) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				if (row_q != RW'(MAX_ROWS - 1)) begin
					row_q <= row_q + RW'(1);
				end
			end else begin
				col_q <= col_inc[CW-1:0];
			end
		end
	end

	// Line buffer: read on accept, write back as the cell leaves the compute stage
	always_ff @(posedge clk) begin
		if (acc) begin
			rd_data_s1 <= line_mem[col_q];
		end
		if (adv1) begin
			line_mem[col_s1] <= size_c;
		end
	end

	// Load the compute stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (acc) begin
			valid_s1 <= 1'b1;
		end else if (adv1) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			free_s1     <= s_axis_tdata[0];
			last_s1     <= s_axis_tlast;
			first_s1    <= (row_q == '0) || (col_q == '0);
			col_s1      <= col_q;
			row_s1      <= row_q;
			fwd_s1      <= adv1 && (col_s1 == col_q);
			fwd_data_s1 <= size_c;
		end
	end

	// Update neighbours and the best square; drop the best at grid end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q     <= '0;
			diag_q     <= '0;
			best_q     <= '0;
			best_row_q <= '0;
			best_col_q <= '0;
		end else if (adv1) begin
			left_q <= size_c;
			diag_q <= up;
			if (last_s1) begin
				best_q     <= '0;
				best_row_q <= '0;
				best_col_q <= '0;
			end else begin
				best_q     <= best_nxt;
				best_row_q <= best_row_nxt;
				best_col_q <= best_col_nxt;
			end
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			out_last_q <= last_s1;
			out_size_q <= size_c;
			out_best_q <= best_nxt;
			out_row_q  <= best_row_nxt;
			out_col_q  <= best_col_nxt;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {
		(lfsf_pkg::OUT_TDATA_W - 2*SW - 2*PW)'(0),
		out_col_q, out_row_q, out_best_q, out_size_q
	};

	// A full compute stage that cannot move is the only reason to refuse a word
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && !adv1))
		else $error("tready low without a stalled compute stage");

	// Back-to-back reads of one entry only occur at column zero
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && fwd_s1) |-> (col_s1 == '0))
		else $error("forward flag away from column zero");

	// The best size reported never falls below the size of its own cell
	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_size_q <= out_best_q))
		else $error("square size above reported best");

	// After a grid's last cell leaves, the best square starts again from zero
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(adv1 && last_s1) |=> (best_q == '0))
		else $error("best square not cleared at grid end");

endmodule

// ===== tb/tb_largest_free_square_finder.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_largest_free_square_finder
// Streams grids of free and obstacle cells through the square finder. A
// shadow copy of the row buffer, the left and diagonal sizes and the best
// square predicts every output word. Each word is then checked field by field
// as it leaves the block. Both stream sides stall at random. The row width
// is moved between grids over small, clamped and full-width settings.
// ----------------------------------------------------------------------------

typedef struct packed {
	logic [lfsf_pkg::SIZE_W-1:0] square_size;
	logic                        grid_done;
	logic [lfsf_pkg::SIZE_W-1:0] best_size;
	logic [lfsf_pkg::POS_W-1:0]  best_row;
	logic [lfsf_pkg::POS_W-1:0]  best_col;
} square_word_t;

// Shadow of the square finder: predicts one output word per accepted cell
class square_tracker;
	bit [lfsf_pkg::SIZE_W-1:0] row_width;
	bit [lfsf_pkg::SIZE_W-1:0] row_above [lfsf_pkg::MAX_COLS_DEF];
	bit [lfsf_pkg::SIZE_W-1:0] left_size;
	bit [lfsf_pkg::SIZE_W-1:0] diag_size;
	bit [lfsf_pkg::SIZE_W-1:0] best_size;
	bit [lfsf_pkg::POS_W-1:0]  col_pos;
	bit [lfsf_pkg::POS_W-1:0]  row_pos;
	bit [lfsf_pkg::POS_W-1:0]  best_row;
	bit [lfsf_pkg::POS_W-1:0]  best_col;
	square_word_t expected_squares [$];
	int squares_seen;
	int mismatches;

	function new();
		row_width    = lfsf_pkg::ROW_WIDTH_RST;
		squares_seen = 0;
		mismatches   = 0;
		restart_grid();
	endfunction

	function void restart_grid();
		left_size = '0;
		diag_size = '0;
		col_pos   = '0;
		row_pos   = '0;
		best_size = '0;
		best_row  = '0;
		best_col  = '0;
	endfunction

	// Work out the square ending at this cell and advance the grid position
	function void note_cell(bit free, bit last);
		int unsigned width;
		int unsigned up;
		int unsigned low;
		int unsigned size;
		square_word_t word;
		if (row_width == 0)
			width = 1;
		else if (row_width > lfsf_pkg::MAX_COLS_DEF)
			width = lfsf_pkg::MAX_COLS_DEF;
		else
			width = row_width;
		up = row_above[col_pos];

		if (!free) begin
			size = 0;
		end else if (row_pos == 0 || col_pos == 0) begin
			size = 1;
		end else begin
			low = left_size;
			if (up < low)
				low = up;
			if (diag_size < low)
				low = diag_size;
			size = low + 1;
			if (size > lfsf_pkg::SIZE_SAT)
				size = lfsf_pkg::SIZE_SAT;
		end

		// Keep the first strictly largest square
		if (size > best_size) begin
			best_size = size;
			best_row  = row_pos;
			best_col  = col_pos;
		end

		word.square_size = lfsf_pkg::SIZE_W'(size);
		word.grid_done   = last;
		word.best_size   = best_size;
		word.best_row    = best_row;
		word.best_col    = best_col;
		expected_squares.push_back(word);

		row_above[col_pos] = lfsf_pkg::SIZE_W'(size);
		diag_size = lfsf_pkg::SIZE_W'(up);
		left_size = lfsf_pkg::SIZE_W'(size);

		if (last) begin
			restart_grid();
		end else if (int'(col_pos) + 1 >= width) begin
			col_pos   = '0;
			left_size = '0;
			diag_size = '0;
			if (row_pos < lfsf_pkg::MAX_ROWS_DEF - 1)
				row_pos++;
		end else begin
			col_pos++;
		end
	endfunction

	task report_mismatch(string what);
		mismatches++;
		$display("mismatch on word %0d: %s", squares_seen, what);
	endtask

	// Compare an output word with the oldest prediction
	task check_square(logic [lfsf_pkg::OUT_TDATA_W-1:0] data, logic done);
		square_word_t want;
		if (expected_squares.size() == 0) begin
			report_mismatch("output word with no cell waiting");
			squares_seen++;
			return;
		end
		want = expected_squares.pop_front();
		if (data[10:0] !== want.square_size)
			report_mismatch($sformatf("square_size %0d, want %0d", data[10:0],
				want.square_size));
		if (done !== want.grid_done)
			report_mismatch($sformatf("grid_done %b, want %b", done, want.grid_done));
		if (data[21:11] !== want.best_size)
			report_mismatch($sformatf("best_size %0d, want %0d", data[21:11],
				want.best_size));
		if (data[31:22] !== want.best_row)
			report_mismatch($sformatf("best_row %0d, want %0d", data[31:22],
				want.best_row));
		if (data[41:32] !== want.best_col)
			report_mismatch($sformatf("best_col %0d, want %0d", data[41:32],
				want.best_col));
		if (data[47:42] !== '0)
			report_mismatch($sformatf("padding %b, want zero", data[47:42]));
		squares_seen++;
	endtask
endclass

module tb_largest_free_square_finder;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_HOLD    = 48;
	localparam int RANDOM_CELLS = 300;
	localparam int STEADY_CELLS = 100;
	localparam int ZERO_CELLS   = 40;
	localparam int WIDE_CELLS   = 1030;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 cfg_wr_en;
	logic [lfsf_pkg::SIZE_W-1:0]          cfg_wr_data;
	logic                                 s_axis_tvalid;
	logic                                 s_axis_tready;
	logic [lfsf_pkg::IN_TDATA_W-1:0]      s_axis_tdata;   // [0] cell_free
	logic                                 s_axis_tlast;   // last_cell
	logic                                 m_axis_tvalid;
	logic                                 m_axis_tready;
	// [10:0] square_size, [21:11] best_size, [31:22] best_row, [41:32] best_col
	logic [lfsf_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
	logic                                 m_axis_tlast;   // grid_done

	square_tracker tracker;
	bit            steady;
	bit            hold_request;
	int            cycle_count;

	largest_free_square_finder i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Offer one cell and hold it until the block takes the word
	task automatic send_cell(input bit free, input bit last);
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= lfsf_pkg::IN_TDATA_W'(free);
		s_axis_tlast  <= last;
		do @(posedge clk); while (s_axis_tready !== 1'b1);
		tracker.note_cell(free, last);
	endtask

	task automatic pause_sender(input int cycles);
		s_axis_tvalid <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Hold the input until every predicted word has left the block
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		do @(posedge clk); while (tracker.expected_squares.size() != 0);
	endtask

	task automatic set_width(input logic [lfsf_pkg::SIZE_W-1:0] width);
		cfg_wr_data <= width;
		cfg_wr_en   <= 1'b1;
		@(posedge clk);
		cfg_wr_en   <= 1'b0;
		tracker.row_width = width;
	endtask

	task automatic send_pattern(input bit [15:0] pattern, input int cells);
		for (int i = 0; i < cells; i++) begin
			if (!steady && $urandom_range(0, 5) == 0)
				pause_sender($urandom_range(1, 6));
			send_cell(pattern[i], i == cells - 1);
		end
	endtask

	// Send one grid of random cells; optionally drain part-way through
	task automatic send_grid(input int cells, input int free_pct, input bit gaps,
		input int pause_at);
		for (int i = 0; i < cells; i++) begin
			if (i == pause_at)
				wait_drained();
			else if (gaps && $urandom_range(0, 5) == 0)
				pause_sender($urandom_range(1, 6));
			send_cell($urandom_range(0, 99) < free_pct, i == cells - 1);
		end
	endtask

	// Output side: random stalls, one long hold-off on request
	initial begin
		int stall;
		bit hold_taken;
		m_axis_tready = 1'b0;
		hold_taken    = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request && !hold_taken) begin
				hold_taken = 1'b1;
				stall = LONG_HOLD;
			end else if (!steady && $urandom_range(0, 3) == 0) begin
				stall = $urandom_range(1, 6);
			end else begin
				stall = 0;
			end
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
		end
	end

	// Check every word that leaves the block
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
				tracker.check_square(m_axis_tdata, m_axis_tlast);
		end
	end

	// Give up on a hung block
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb_largest_free_square_finder: errors");
		$finish;
	end

	initial begin
		int random_count;
		int width;
		int rows;
		int cells;
		int pct;
		int pause_at;
		tracker       = new();
		arst_n        = 1'b0;
		cfg_wr_en     = 1'b0;
		cfg_wr_data   = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tlast  = 1'b0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: 4-wide grid with obstacles, interior squares and a tie,
		// then an all-obstacle grid ending mid-row and a one-cell grid
		set_width(11'd4);
		send_pattern(16'h0EFB, 12);
		send_pattern(16'h0000, 3);
		send_pattern(16'h0001, 1);

		// Zero width acts as one column
		wait_drained();
		set_width(11'd0);
		send_grid(ZERO_CELLS, 85, 1'b1, -1);

		// Oversized width clamps to full width; wraps into a second row
		wait_drained();
		set_width(11'h7FF);
		send_grid(WIDE_CELLS, 97, 1'b1, -1);

		// Fill the block behind a long output hold, then drain mid-grid
		wait_drained();
		set_width(11'd16);
		hold_request = 1'b1;
		send_grid(96, 90, 1'b0, 70);
		random_count = 96;

		// Random grids over mostly small widths; no idling at the end
		while (random_count < RANDOM_CELLS) begin
			wait_drained();
			steady = (random_count >= RANDOM_CELLS - STEADY_CELLS);
			case ($urandom_range(0, 5))
				0: begin
					width = 1;
				end
				1: begin
					width = 2;
				end
				2: begin
					width = $urandom_range(3, 8);
				end
				5: begin
					width = $urandom_range(25, 64);
				end
				default: begin
					width = $urandom_range(4, 24);
				end
			endcase
			set_width(lfsf_pkg::SIZE_W'(width));
			repeat ($urandom_range(1, 3)) begin
				rows = $urandom_range(1, (width <= 8) ? 12 : 5);
				cells = width * rows;
				if ($urandom_range(0, 2) == 0)
					cells = cells - $urandom_range(0, width - 1);
				// Keep the run close to its budget
				if (cells > RANDOM_CELLS - random_count)
					cells = RANDOM_CELLS - random_count;
				if (cells < 1)
					cells = 1;
				case ($urandom_range(0, 3))
					0: begin
						pct = 50;
					end
					1: begin
						pct = 80;
					end
					2: begin
						pct = 90;
					end
					default: begin
						pct = 97;
					end
				endcase
				pause_at = (!steady && $urandom_range(0, 7) == 0) ?
					$urandom_range(0, cells - 1) : -1;
				send_grid(cells, pct, !steady, pause_at);
				random_count += cells;
			end
		end

		// Let the pipeline empty and catch any stray words
		wait_drained();
		repeat (8) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.expected_squares.size() == 0)
			$display("tb_largest_free_square_finder: clean");
		else
			$display("tb_largest_free_square_finder: errors");
		$finish;
	end

endmodule
